[design/psieve_pkg.sv]
package psieve_pkg;

  localparam int LIMIT_W     = 9;
  localparam int PRIME_W     = 9;
  localparam int MAX_RESULTS = 64;
  localparam int FIRST_CAND  = 2;
  localparam int SIZE_DEF    = 256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MARK,
    ST_FINAL,
    ST_EMPTY
  } sieve_state_e;

  // bitmap port command: one access per cycle
  typedef struct packed {
    logic wr;
    logic rd;
    logic wdata;
  } map_cmd_t;

endpackage

[design/psieve_map.sv]
module psieve_map #(
  parameter int DEPTH = psieve_pkg::SIZE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  psieve_pkg::map_cmd_t cmd_i,
  input  logic [AW-1:0]       addr_i,
  output logic                rdata_o
);
  import psieve_pkg::*;

  logic mem [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[addr_i] <= cmd_i.wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/psieve_ctrl.sv]
module psieve_ctrl #(
  parameter int SIZE = psieve_pkg::SIZE_DEF,
  parameter int AW   = $clog2(SIZE)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [psieve_pkg::LIMIT_W-1:0] limit_i,
  output logic                          busy,
  output logic                          result_valid_o,
  output logic [psieve_pkg::PRIME_W-1:0] prime_o,
  output logic                          last_o,
  output logic                          empty_res_o,
  output psieve_pkg::map_cmd_t          map_cmd_o,
  output logic [AW-1:0]                 map_addr_o,
  input  logic                          map_rdata_i
);
  import psieve_pkg::*;

  localparam int NMAX_I = (SIZE < (2**LIMIT_W - 1)) ? SIZE : (2**LIMIT_W - 1);
  localparam logic [LIMIT_W-1:0] NMAX = LIMIT_W'(NMAX_I);
  localparam int PW = LIMIT_W + 1;          // candidate value, slot + 2
  localparam int MW = 2 * PW;               // holds p*p
  localparam int CNTW = $clog2(MAX_RESULTS);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(MAX_RESULTS - 1);

  sieve_state_e state_q, state_d;

  logic [LIMIT_W-1:0] n_q;
  logic [LIMIT_W-1:0] s_q;
  logic [MW-1:0]      m_q;
  logic [PRIME_W-1:0] pend_q;
  logic               have_pend_q;
  logic [CNTW-1:0]    cnt_q;

  logic [LIMIT_W-1:0] n_sat;
  logic [PW-1:0]      p_w;
  logic [MW-1:0]      sq_w;
  logic               slot_end;
  logic               mark_in;

  assign n_sat    = (limit_i > NMAX) ? NMAX : limit_i;
  assign p_w      = PW'(s_q) + PW'(FIRST_CAND);
  assign sq_w     = MW'(p_w) * MW'(p_w);
  assign slot_end = (s_q == (n_q - LIMIT_W'(1)));
  assign mark_in  = (m_q < MW'(n_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = (n_sat == '0) ? ST_EMPTY : ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (slot_end) state_d = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (!map_rdata_i) begin
          state_d = (cnt_q == CNT_LAST) ? ST_FINAL : ST_MARK;
        end else begin
          state_d = slot_end ? ST_FINAL : ST_SCAN_RD;
        end
      end
      ST_MARK: begin
        if (!mark_in) state_d = slot_end ? ST_FINAL : ST_SCAN_RD;
      end
      ST_FINAL: state_d = ST_IDLE;
      ST_EMPTY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy           = 1'b1;
    result_valid_o = 1'b0;
    prime_o        = pend_q;
    last_o         = 1'b0;
    empty_res_o    = 1'b0;
    map_cmd_o      = '0;
    map_addr_o     = AW'(s_q);
    case (state_q)
      ST_IDLE: busy = 1'b0;
      ST_CLEAR: begin
        map_cmd_o.wr = 1'b1;
      end
      ST_SCAN_RD: begin
        map_cmd_o.rd = 1'b1;
      end
      ST_SCAN_CHK: begin
        // a new prime releases the one held back
        result_valid_o = !map_rdata_i && have_pend_q;
      end
      ST_MARK: begin
        map_cmd_o.wr    = mark_in;
        map_cmd_o.wdata = 1'b1;
        map_addr_o      = AW'(m_q);
      end
      ST_FINAL: begin
        result_valid_o = 1'b1;
        last_o         = 1'b1;
      end
      ST_EMPTY: begin
        result_valid_o = 1'b1;
        last_o         = 1'b1;
        empty_res_o    = 1'b1;
        prime_o        = '0;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      s_q         <= '0;
      m_q         <= '0;
      pend_q      <= '0;
      have_pend_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            n_q         <= n_sat;
            s_q         <= '0;
            have_pend_q <= 1'b0;
            cnt_q       <= '0;
          end
        end
        ST_CLEAR: begin
          s_q <= slot_end ? '0 : s_q + LIMIT_W'(1);
        end
        ST_SCAN_CHK: begin
          if (!map_rdata_i) begin
            pend_q      <= PRIME_W'(p_w);
            have_pend_q <= 1'b1;
            cnt_q       <= cnt_q + CNTW'(1);
            m_q         <= sq_w - MW'(FIRST_CAND);
          end else if (!slot_end) begin
            s_q <= s_q + LIMIT_W'(1);
          end
        end
        ST_MARK: begin
          if (mark_in) begin
            m_q <= m_q + MW'(p_w);
          end else if (!slot_end) begin
            s_q <= s_q + LIMIT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[design/prime_sieve_engine.sv]
// Channel  Ports                                   Direction  Handshake
// request  start, limit_i                          in         start && !busy
// result   result_valid_o, prime_o, last_o,        out        result_valid_o, one cycle
//          empty_res_o
//
// A request clears the n bitmap slots, n = min(limit, SIZE), then reads and checks each
// scanned slot, writes each bitmap mark (M, about n ln ln n), closes the marking pass of
// each prime found and emits the last prime. The single-port bitmap takes one access
// a cycle. Scanning stops after 64 primes. A zero count gives its result in the cycle
// after acceptance. Reset is asynchronous, active low; busy is high from acceptance
// through the last result; no result stalls.
module prime_sieve_engine #(
  parameter int SIZE = psieve_pkg::SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [psieve_pkg::LIMIT_W-1:0] limit_i,
  output logic                          busy,
  output logic                          result_valid_o,
  output logic [psieve_pkg::PRIME_W-1:0] prime_o,
  output logic                          last_o,
  output logic                          empty_res_o
);
  import psieve_pkg::*;

  localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;

  map_cmd_t      map_cmd;
  logic [AW-1:0] map_addr;
  logic          map_rdata;

  psieve_ctrl #(
    .SIZE (SIZE),
    .AW   (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .limit_i        (limit_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .prime_o        (prime_o),
    .last_o         (last_o),
    .empty_res_o    (empty_res_o),
    .map_cmd_o      (map_cmd),
    .map_addr_o     (map_addr),
    .map_rdata_i    (map_rdata)
  );

  psieve_map #(
    .DEPTH (SIZE),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .cmd_i   (map_cmd),
    .addr_i  (map_addr),
    .rdata_o (map_rdata)
  );

endmodule
